/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock and active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/fsmf_pkg.sv */
// ---------------------------------------------------------------------------
// First substring match finder package
// Sizes and shared types for the matcher and its output buffer.
// ---------------------------------------------------------------------------
package fsmf_pkg;

    localparam int MAX_NEEDLE     = 64;
    localparam int IDX_BITS       = $clog2(MAX_NEEDLE);
    localparam int SLOT_BITS      = 6;
    localparam int LEN_BITS       = 7;
    localparam int BYTE_BITS      = 8;
    localparam int POSITION_BITS  = 32;
    localparam int MATCH_POS_BITS = 32;

    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(MAX_NEEDLE);

    localparam logic FUNC_NEEDLE   = 1'b0;
    localparam logic FUNC_HAYSTACK = 1'b1;

    typedef struct packed {
        logic                      found;
        logic [MATCH_POS_BITS-1:0] match_position;
    } t_result;

    typedef struct packed {
        logic search_done;
        logic live_any;
    } t_status;

endpackage

/* rtl/core/fsmf_matcher.sv */
// ---------------------------------------------------------------------------
// Shift-and matcher
// Holds the needle, its length and the search state, and updates the live
// prefix vector for each accepted haystack byte until the search is done.
// ---------------------------------------------------------------------------
module fsmf_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fsmf_pkg::LEN_BITS-1:0]   i_cfg_wdata,
    input  logic                            i_acc,
    input  logic                            i_func,
    input  logic [fsmf_pkg::SLOT_BITS-1:0]  i_needle_slot,
    input  logic [fsmf_pkg::BYTE_BITS-1:0]  i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_res_valid,
    output fsmf_pkg::t_result               o_res,
    output fsmf_pkg::t_status               o_status
);
    import fsmf_pkg::*;

    logic [BYTE_BITS-1:0]     r_needle [MAX_NEEDLE];
    logic [LEN_BITS-1:0]      r_len;
    logic [MAX_NEEDLE-1:0]    r_live;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_done;

    logic [MAX_NEEDLE-1:0]    n_live;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     n_done;

    logic [LEN_BITS-1:0]      len_used;
    logic [MAX_NEEDLE-1:0]    eq;
    logic [MAX_NEEDLE-1:0]    live_shift;
    logic [IDX_BITS-1:0]      last_idx;
    logic [POSITION_BITS-1:0] start_pos;
    logic                     slot_ok;

    assign len_used   = (r_len > LEN_MAX) ? LEN_MAX : r_len;
    assign live_shift = {r_live[MAX_NEEDLE-2:0], 1'b1} & eq;
    assign last_idx   = IDX_BITS'(len_used - LEN_BITS'(1));
    assign start_pos  = r_pos - POSITION_BITS'(len_used) + POSITION_BITS'(1);
    assign slot_ok    = ({1'b0, i_needle_slot} < LEN_MAX);

    always_comb begin
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            eq[i] = (r_needle[i] == i_data_byte) && (LEN_BITS'(i) < len_used);
        end
    end

    always_comb begin
        n_live               = r_live;
        n_pos                = r_pos;
        n_done               = r_done;
        o_res_valid          = 1'b0;
        o_res.found          = 1'b0;
        o_res.match_position = '0;
        if (i_acc && (i_func == FUNC_HAYSTACK)) begin
            if (!r_done) begin
                n_pos = r_pos + POSITION_BITS'(1);
                if (len_used == '0) begin
                    o_res_valid = 1'b1;
                    o_res.found = 1'b1;
                    n_done      = 1'b1;
                end else begin
                    n_live = live_shift;
                    if (live_shift[last_idx]) begin
                        o_res_valid          = 1'b1;
                        o_res.found          = 1'b1;
                        o_res.match_position = MATCH_POS_BITS'(start_pos);
                        n_done               = 1'b1;
                    end
                end
            end
            if (i_last_byte) begin
                if (!n_done) begin
                    o_res_valid = 1'b1;
                end
                n_live = '0;
                n_pos  = '0;
                n_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && (i_func == FUNC_NEEDLE) && slot_ok) begin
            r_needle[IDX_BITS'(i_needle_slot)] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_live <= '0;
            r_pos  <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_live <= n_live;
            r_pos  <= n_pos;
            r_done <= n_done;
        end
    end

    assign o_status.search_done = r_done;
    assign o_status.live_any    = |r_live;

endmodule

/* rtl/core/fsmf_out_buf.sv */
// ---------------------------------------------------------------------------
// Result buffer
// Two-entry buffer that decouples result delivery from input acceptance.
// ---------------------------------------------------------------------------
module fsmf_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fsmf_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    output fsmf_pkg::t_result o_data,
    input  logic              i_stall
);
    import fsmf_pkg::*;

    t_result    r_buf [2];
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic [1:0] r_count;

    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_buf[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/first_substring_match_finder_top.sv */
// ---------------------------------------------------------------------------
// First substring match finder
// Streams haystack bytes through a shift-and matcher against a loaded
// needle and reports the start of the first match or its absence.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    func, needle_slot, data_byte, last_byte
// output    out        o_out_valid / i_out_stall  found, match_position
// config    in         i_cfg_we                   needle_length
//
// One transaction is accepted per cycle unless the input stalls; any result it yields
// enters the output buffer at the same edge and is visible the next cycle.
// The live prefix update is a single compare and shift, so the rate is one
// byte per cycle while not stalled. Reset clears the search state and sets the length to one.
// The input stalls only while both output buffer entries hold results.
// ---------------------------------------------------------------------------
module first_substring_match_finder_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fsmf_pkg::LEN_BITS-1:0]         i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_func,
    input  logic [fsmf_pkg::SLOT_BITS-1:0]        i_needle_slot,
    input  logic [fsmf_pkg::BYTE_BITS-1:0]        i_data_byte,
    input  logic                                  i_last_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_found,
    output logic [fsmf_pkg::MATCH_POS_BITS-1:0]   o_match_position
);
    import fsmf_pkg::*;
    `include "assert_macros.svh"

    logic    in_acc;
    logic    res_valid;
    t_result res;
    t_result out_data;
    t_status status;
    logic    buf_full;

    assign in_acc     = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    fsmf_matcher u_matcher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_acc         (in_acc),
        .i_func        (i_func),
        .i_needle_slot (i_needle_slot),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_status      (status)
    );

    fsmf_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_stall (i_out_stall)
    );

    assign o_found          = out_data.found;
    assign o_match_position = out_data.match_position;

    `ASSERT_SAME(a_not_found_pos_zero, i_clk, i_rst_n, o_out_valid && !o_found, o_match_position == '0)
    `ASSERT_SAME(a_stall_has_results, i_clk, i_rst_n, o_in_stall, o_out_valid)
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, in_acc && (i_func == FUNC_HAYSTACK) && i_last_byte, !status.search_done && !status.live_any)
    `ASSERT_SAME(a_done_no_live_hit, i_clk, i_rst_n, res_valid && !res.found, !status.search_done)

endmodule

/* test/substring_match_checker.sv */
// ---------------------------------------------------------------------------
// Substring match checker
// Watches the input, output and configuration ports of the first substring
// match finder. Predicts each search result with its own shift-and matcher,
// compares each output transaction field by field with the oldest expected
// result, and hands the mismatch count and the number of outstanding results
// to the testbench top.
// ---------------------------------------------------------------------------
module substring_match_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fsmf_pkg::LEN_BITS-1:0]         i_cfg_wdata,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic                                  i_func,
    input  logic [fsmf_pkg::SLOT_BITS-1:0]        i_needle_slot,
    input  logic [fsmf_pkg::BYTE_BITS-1:0]        i_data_byte,
    input  logic                                  i_last_byte,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic                                  i_found,
    input  logic [fsmf_pkg::MATCH_POS_BITS-1:0]   i_match_position,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import fsmf_pkg::*;

    logic [BYTE_BITS-1:0]     needle_bytes [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0]    alive;
    logic [POSITION_BITS-1:0] next_index;
    logic                     search_over;
    logic [LEN_BITS-1:0]      length_reg;
    t_result                  expected_results [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic predict_search_step(input logic func, input logic [SLOT_BITS-1:0] slot,
                                       input logic [BYTE_BITS-1:0] data, input logic last);
        int                    n;
        logic [MAX_NEEDLE-1:0] eq;
        t_result               res;
        if (func == FUNC_NEEDLE) begin
            needle_bytes[slot] = data;
            return;
        end
        n = (length_reg > LEN_MAX) ? MAX_NEEDLE : int'(length_reg);
        if (!search_over) begin
            if (n == 0) begin
                res.found          = 1'b1;
                res.match_position = '0;
                expected_results.push_back(res);
                search_over = 1'b1;
            end else begin
                eq = '0;
                for (int i = 0; i < n; i++) begin
                    if (needle_bytes[i] == data) begin
                        eq[i] = 1'b1;
                    end
                end
                alive = ((alive << 1) | MAX_NEEDLE'(1)) & eq;
                if (alive[n-1]) begin
                    res.found          = 1'b1;
                    res.match_position = MATCH_POS_BITS'(next_index - POSITION_BITS'(n)
                                                         + POSITION_BITS'(1));
                    expected_results.push_back(res);
                    search_over = 1'b1;
                end
            end
            next_index = next_index + POSITION_BITS'(1);
        end
        if (last) begin
            if (!search_over) begin
                res.found          = 1'b0;
                res.match_position = '0;
                expected_results.push_back(res);
            end
            alive       = '0;
            next_index  = '0;
            search_over = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            alive       = '0;
            next_index  = '0;
            search_over = 1'b0;
            length_reg  = LEN_RESET;
            expected_results.delete();
        end else begin
            // Results leave before this edge's input is predicted, since a
            // result becomes visible in the cycle after its input transaction.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: found=%0b pos=%0d",
                                              i_found, i_match_position));
                end else begin
                    want = expected_results.pop_front();
                    if (i_found !== want.found) begin
                        report_mismatch($sformatf("found is %0b, expected %0b",
                                                  i_found, want.found));
                    end
                    if (i_match_position !== want.match_position) begin
                        report_mismatch($sformatf("match_position is %0d, expected %0d",
                                                  i_match_position, want.match_position));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_search_step(i_func, i_needle_slot, i_data_byte, i_last_byte);
            end
            if (i_cfg_we) begin
                length_reg = i_cfg_wdata;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* test/testbench.sv */
// ---------------------------------------------------------------------------
// First substring match finder testbench
// Loads needles of many lengths, streams haystacks with planted, broken and
// overlapping matches under random sender gaps and receiver stalls, and lets
// the checker compare every search result with its own prediction.
// ---------------------------------------------------------------------------
module testbench;
    import fsmf_pkg::*;

    localparam int ITEM_TARGET   = 1950;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [LEN_BITS-1:0]       i_cfg_wdata      = '0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    logic                      i_func           = FUNC_NEEDLE;
    logic [SLOT_BITS-1:0]      i_needle_slot    = '0;
    logic [BYTE_BITS-1:0]      i_data_byte      = '0;
    logic                      i_last_byte      = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic                      o_found;
    logic [MATCH_POS_BITS-1:0] o_match_position;

    int fail_count;
    int pending_results;
    int items_sent      = 0;
    int haystack_bytes  = 0;
    int searches_run    = 0;
    int length_settings = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;
    int stall_pct       = 0;
    int stall_run       = 0;
    int alphabet_size   = 0;

    logic [BYTE_BITS-1:0] alphabet [4];
    logic [BYTE_BITS-1:0] needle   [MAX_NEEDLE];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    first_substring_match_finder_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_needle_slot    (i_needle_slot),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_match_position (o_match_position)
    );

    substring_match_checker match_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_needle_slot    (i_needle_slot),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_found          (o_found),
        .i_match_position (o_match_position),
        .o_fail_count     (fail_count),
        .o_pending        (pending_results)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
            stall_pct   <= 0;
        end else begin
            if (stall_run == 0) begin
                stall_run <= $urandom_range(10, 150);
                case ($urandom_range(0, 3))
                    0: begin
                        stall_pct <= 0;
                    end
                    1: begin
                        stall_pct <= 25;
                    end
                    2: begin
                        stall_pct <= 50;
                    end
                    default: begin
                        stall_pct <= 80;
                    end
                endcase
            end else begin
                stall_run <= stall_run - 1;
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("No transaction for %0d cycles, %0d results outstanding.",
                     IDLE_LIMIT, pending_results);
            $display("FAIL first_substring_match_finder_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drive_item(input logic func, input logic [SLOT_BITS-1:0] slot,
                              input logic [BYTE_BITS-1:0] data, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_needle_slot <= slot;
        i_data_byte   <= data;
        i_last_byte   <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (func == FUNC_HAYSTACK) begin
            haystack_bytes++;
        end
    endtask

    task automatic set_needle_length(input logic [LEN_BITS-1:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        length_settings++;
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_symbol();
        if (alphabet_size == 0 || $urandom_range(0, 19) == 0) begin
            return BYTE_BITS'($urandom_range(0, 255));
        end
        return alphabet[$urandom_range(0, alphabet_size - 1)];
    endfunction

    task automatic run_phase(input int phase);
        int                   cfg_len;
        int                   used;
        int                   hay_len;
        int                   plant_at;
        int                   searches;
        logic [SLOT_BITS-1:0] wr_slot;
        logic [BYTE_BITS-1:0] b;
        if (phase == 0) begin
            cfg_len = 127;
        end else if (phase == 1) begin
            cfg_len = MAX_NEEDLE;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    cfg_len = 0;
                end
                1: begin
                    cfg_len = MAX_NEEDLE;
                end
                2: begin
                    cfg_len = $urandom_range(MAX_NEEDLE + 1, 127);
                end
                3: begin
                    cfg_len = $urandom_range(13, MAX_NEEDLE - 1);
                end
                default: begin
                    cfg_len = $urandom_range(1, 12);
                end
            endcase
        end
        set_needle_length(LEN_BITS'(cfg_len));
        used = (cfg_len > MAX_NEEDLE) ? MAX_NEEDLE : cfg_len;

        alphabet_size = $urandom_range(0, 4);
        foreach (alphabet[i]) begin
            alphabet[i] = BYTE_BITS'($urandom_range(0, 255));
        end

        // Every slot the matcher reads is written before the first haystack byte.
        for (int i = 0; i < used; i++) begin
            needle[i] = pick_symbol();
            drive_item(FUNC_NEEDLE, SLOT_BITS'(i), needle[i], 1'($urandom_range(0, 1)));
        end
        if (used < MAX_NEEDLE) begin
            repeat ($urandom_range(0, 2)) begin
                wr_slot         = SLOT_BITS'($urandom_range(used, MAX_NEEDLE - 1));
                needle[wr_slot] = BYTE_BITS'($urandom_range(0, 255));
                drive_item(FUNC_NEEDLE, wr_slot, needle[wr_slot], 1'($urandom_range(0, 1)));
            end
        end

        searches = $urandom_range(1, 4);
        repeat (searches) begin
            if (used == 0) begin
                hay_len = $urandom_range(1, 5);
            end else if (used > 12) begin
                hay_len = $urandom_range(used, 2 * used + 8);
            end else begin
                hay_len = $urandom_range(1, 40);
            end
            plant_at = ($urandom_range(0, 3) != 0 && hay_len >= used)
                       ? $urandom_range(0, hay_len - used) : -1;
            for (int p = 0; p < hay_len; p++) begin
                if ($urandom_range(0, 39) == 0) begin
                    wr_slot         = SLOT_BITS'($urandom_range(0, MAX_NEEDLE - 1));
                    needle[wr_slot] = BYTE_BITS'($urandom_range(0, 255));
                    drive_item(FUNC_NEEDLE, wr_slot, needle[wr_slot],
                               1'($urandom_range(0, 1)));
                end
                if (plant_at >= 0 && p >= plant_at && p < plant_at + used
                        && $urandom_range(0, 29) != 0) begin
                    b = needle[p - plant_at];
                end else begin
                    b = pick_symbol();
                end
                drive_item(FUNC_HAYSTACK, SLOT_BITS'($urandom_range(0, 63)), b,
                           p == hay_len - 1);
            end
            searches_run++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-byte needle at the reset length: a match in the middle, bytes
        // after a match, a match on the last byte, and a haystack with no match.
        drive_item(FUNC_NEEDLE, 6'd0, 8'hFF, 1'b1);
        drive_item(FUNC_HAYSTACK, 6'h3F, 8'h00, 1'b0);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hFF, 1'b0);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'h55, 1'b1);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hFF, 1'b1);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'h00, 1'b1);
        searches_run += 3;

        // An empty needle matches at the first byte of each search.
        set_needle_length(LEN_BITS'(0));
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hAB, 1'b0);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hFF, 1'b1);
        searches_run++;

        // Needle rewritten in the middle of a search, then an overlapping prefix.
        set_needle_length(LEN_BITS'(2));
        drive_item(FUNC_NEEDLE, 6'd63, 8'h80, 1'b0);
        drive_item(FUNC_NEEDLE, 6'd1, 8'h01, 1'b1);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hFF, 1'b0);
        drive_item(FUNC_NEEDLE, 6'd1, 8'h7F, 1'b0);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'h7F, 1'b1);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hFF, 1'b0);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'hFF, 1'b0);
        drive_item(FUNC_HAYSTACK, 6'd0, 8'h7F, 1'b1);
        searches_run += 2;

        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            run_phase(phase);
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions, %0d haystack bytes, in %0d searches.",
                 items_sent, haystack_bytes, searches_run);
        $display("Needle length changed %0d times, from empty to beyond the store size.",
                 length_settings);
        if (fail_count == 0) begin
            $display("PASS first_substring_match_finder_top");
        end else begin
            $display("FAIL first_substring_match_finder_top");
        end
        $finish;
    end

endmodule
